// File: src/selective_repeat_arq_sender_defines.svh
// Assertion macros used by the selective-repeat ARQ sender top level.
`ifndef SELECTIVE_REPEAT_ARQ_SENDER_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_SENDER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication check.
`define SRARQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srarq: same-cycle check failed");
// Next-cycle implication check.
`define SRARQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srarq: next-cycle check failed");
`else
`define SRARQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRARQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/srarq_pkg.sv
// Shared types, constants and codes for the selective-repeat ARQ sender.
`default_nettype none
package srarq_pkg;

  // Default geometry
  localparam int WINDOW_MAX_DEF = 16;
  localparam int SEQ_SPACE_DEF  = 32;

  // Field widths
  localparam int IDX_W     = 24;
  localparam int CMD_W     = 2;
  localparam int ACK_W     = 8;
  localparam int KIND_W    = 2;
  localparam int SEQ_NUM_W = 5;
  localparam int WS_W      = 5;
  localparam int TO_W      = 16;
  localparam int CNT_W     = 7;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // Register reset values
  localparam logic [WS_W-1:0]  WS_RESET = WS_W'(10);
  localparam logic [TO_W-1:0]  TO_RESET = TO_W'(500);
  localparam logic [CNT_W-1:0] MR_RESET = CNT_W'(50);

  // Register indexes (word address)
  localparam logic [1:0] REG_WIN_SLOTS     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES   = 2'd2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FAIL   = 2'd3;

  // Info ack, carries no sequence number
  localparam logic [ACK_W-1:0] INFO_ACK = 8'hFF;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] segment_total;
    logic [ACK_W-1:0] ack_sequence;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [IDX_W-1:0]     segment_index;
    logic [SEQ_NUM_W-1:0] sequence_number;
    logic                 final_segment;
    logic                 last_of_run;
  } result_t;

  typedef struct packed {
    logic [WS_W-1:0]  win_slots;
    logic [TO_W-1:0]  timeout_ticks;
    logic [CNT_W-1:0] max_retries;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_LOAD,
    OP_SEND,
    OP_TICK,
    OP_ACK,
    OP_SLIDE,
    OP_DONE,
    OP_FAIL,
    OP_FLUSH
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic active;
    logic total_zero;
    logic send_ok;
    logic send_over;
    logic scan_ok;
    logic tick_over;
    logic ack_hit;
    logic slide_ok;
    logic base_done;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_TICK,
    ST_ACKSCAN,
    ST_SLIDE,
    ST_DONE,
    ST_FAIL,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// File: src/selective_repeat_arq_sender.sv
// Top level of the selective-repeat ARQ sender window.
`default_nettype none
`include "selective_repeat_arq_sender_defines.svh"
// A command is taken when start is high and busy is low; if it has work, busy stays high
// until the command's work is finished. Results leave one per cycle
// on result, each marked by a one-cycle result_valid, and cannot be held off:
// the receiver must take every beat. The beat with last_of_run set closes the
// command and shows in the first cycle busy is low again. Work walks the window
// one slot per cycle: a start sends what the window allows, a tick scans the window and
// resends each timed-out segment, an ack scans for its slot, then slides the base and
// sends new segments (scan, slide, new sends); a command with no effect leaves busy low.
// A failure or done report has a state of its own. No clearing pass follows reset.
module selective_repeat_arq_sender import srarq_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int SEQ_SPACE  = SEQ_SPACE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  item_t             item,
  output logic              busy,
  output result_t           result,
  output logic              result_valid,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  dp_op_t   op;
  dp_stat_t stat;

  srarq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srarq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  srarq_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .SEQ_SPACE  (SEQ_SPACE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .item         (item),
    .cfg          (cfg),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

  // The closing beat arrives once the controller is idle again
  `SRARQ_ASSERT_IMP(a_last_when_idle, clk, rst, result_valid && result.last_of_run, !busy)
  // Earlier beats of a command arrive while it is still at work
  `SRARQ_ASSERT_IMP(a_mid_when_busy, clk, rst, result_valid && !result.last_of_run, busy)
  // A failure always ends the command
  `SRARQ_ASSERT_IMP(a_fail_is_last, clk, rst,
    result_valid && result.kind == KIND_FAIL, result.last_of_run)
  // Nothing follows a closing beat until a new command is taken
  `SRARQ_ASSERT_NXT(a_quiet_after_last, clk, rst,
    result_valid && result.last_of_run, !result_valid)

endmodule
`default_nettype wire

// File: src/srarq_regs.sv
// APB configuration registers: window size, timeout and retry limit.
`default_nettype none
module srarq_regs import srarq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_slots     <= WS_RESET;
      cfg.timeout_ticks <= TO_RESET;
      cfg.max_retries   <= MR_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_WIN_SLOTS:     cfg.win_slots     <= pwdata[WS_W-1:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[TO_W-1:0];
        REG_MAX_RETRIES:   cfg.max_retries   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      REG_WIN_SLOTS:     prdata = APB_DW'(cfg.win_slots);
      REG_TIMEOUT_TICKS: prdata = APB_DW'(cfg.timeout_ticks);
      REG_MAX_RETRIES:   prdata = APB_DW'(cfg.max_retries);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/srarq_dp.sv
// Window datapath: pointers, per-slot flags/ages/counts and the result register.
`default_nettype none
module srarq_dp import srarq_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int SEQ_SPACE  = SEQ_SPACE_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_op_t   op,
  input  item_t    item,
  input  cfg_t     cfg,
  output dp_stat_t stat,
  output result_t  result,
  output logic     result_valid
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int WCNT_W = $clog2(WINDOW_MAX + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
  localparam logic [SEQ_W-1:0]  SEQ_LAST  = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [WCNT_W-1:0] WIN_FULL  = WCNT_W'(WINDOW_MAX);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
    return (p == SLOT_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == SEQ_LAST) ? '0 : s + 1'b1;
  endfunction

  // Window pointers with their slot and sequence residues
  logic [IDX_W-1:0]  base, nxt, total, cur;
  logic [SLOT_W-1:0] base_slot, nxt_slot, cur_slot;
  logic [SEQ_W-1:0]  base_seq, nxt_seq, cur_seq;
  logic              active;
  logic [ACK_W-1:0]  ack;

  // Slot table
  logic [WINDOW_MAX-1:0] acked, sent;
  logic [TO_W-1:0]       age [WINDOW_MAX];
  logic [CNT_W-1:0]      cnt [WINDOW_MAX];

  // Held result, released once the next one is known
  result_t pend;
  result_t pend_last;
  logic    pend_valid;

  logic [WCNT_W-1:0] w_eff;
  logic [IDX_W:0]    win_end;
  logic [TO_W-1:0]   age_inc;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W-1:0]  cnt_sat;
  logic              tick_due, tick_hit, tick_over;
  logic              push;
  result_t           res_new;

  // Effective window and its end
  always_comb begin
    if (cfg.win_slots == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(cfg.win_slots) > 32'(WINDOW_MAX)) begin
      w_eff = WIN_FULL;
    end else begin
      w_eff = WCNT_W'(cfg.win_slots);
    end
  end
  assign win_end = {1'b0, base} + (IDX_W + 1)'(w_eff);

  // Tick check for the scanned slot
  assign age_inc   = (age[cur_slot] != '1) ? age[cur_slot] + 1'b1 : age[cur_slot];
  assign cnt_inc   = {1'b0, cnt[cur_slot]} + (CNT_W + 1)'(1);
  assign cnt_sat   = cnt_inc[CNT_W] ? '1 : cnt_inc[CNT_W-1:0];
  assign tick_due  = sent[cur_slot] && !acked[cur_slot];
  assign tick_hit  = tick_due && (age_inc >= cfg.timeout_ticks);
  assign tick_over = tick_hit && (cnt_inc > {1'b0, cfg.max_retries});

  // Status to the controller
  always_comb begin
    stat.active     = active;
    stat.total_zero = (item.segment_total == '0);
    stat.send_ok    = ({1'b0, nxt} < win_end) && (nxt < total);
    stat.send_over  = (cfg.max_retries == '0);
    stat.scan_ok    = ({1'b0, cur} < win_end) && (cur < total);
    stat.tick_over  = tick_over;
    stat.ack_hit    = !acked[cur_slot] && (ACK_W'(cur_seq) == ack);
    stat.slide_ok   = (base < total) && acked[base_slot];
    stat.base_done  = (base >= total);
  end

  // New result for this cycle
  always_comb begin
    res_new = '0;
    push    = 1'b0;
    case (op)
      OP_SEND: begin
        push                    = 1'b1;
        res_new.kind            = KIND_FIRST;
        res_new.segment_index   = nxt;
        res_new.sequence_number = SEQ_NUM_W'(nxt_seq);
        res_new.final_segment   = (nxt == total - 1'b1);
      end
      OP_TICK: begin
        push                    = tick_hit;
        res_new.kind            = KIND_RESEND;
        res_new.segment_index   = cur;
        res_new.sequence_number = SEQ_NUM_W'(cur_seq);
        res_new.final_segment   = (cur == total - 1'b1);
      end
      OP_DONE: begin
        push         = 1'b1;
        res_new.kind = KIND_DONE;
      end
      OP_FAIL: begin
        push         = 1'b1;
        res_new.kind = KIND_FAIL;
      end
      default: ;
    endcase
  end

  // Pointers and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      nxt       <= '0;
      total     <= '0;
      base_slot <= '0;
      nxt_slot  <= '0;
      base_seq  <= '0;
      nxt_seq   <= '0;
      active    <= 1'b0;
      acked     <= '0;
      sent      <= '0;
    end else begin
      case (op)
        OP_START: begin
          base      <= '0;
          nxt       <= '0;
          total     <= item.segment_total;
          base_slot <= '0;
          nxt_slot  <= '0;
          base_seq  <= '0;
          nxt_seq   <= '0;
          active    <= 1'b1;
          acked     <= '0;
          sent      <= '0;
        end
        OP_SEND: begin
          acked[nxt_slot] <= 1'b0;
          sent[nxt_slot]  <= 1'b1;
          nxt             <= nxt + 1'b1;
          nxt_slot        <= slot_inc(nxt_slot);
          nxt_seq         <= seq_inc(nxt_seq);
        end
        OP_ACK: begin
          if (stat.ack_hit) begin
            acked[cur_slot] <= 1'b1;
          end
        end
        OP_SLIDE: begin
          if (stat.slide_ok) begin
            acked[base_slot] <= 1'b0;
            sent[base_slot]  <= 1'b0;
            base             <= base + 1'b1;
            base_slot        <= slot_inc(base_slot);
            base_seq         <= seq_inc(base_seq);
          end else if (nxt < base) begin
            nxt      <= base;
            nxt_slot <= base_slot;
            nxt_seq  <= base_seq;
          end
        end
        OP_DONE, OP_FAIL: active <= 1'b0;
        default: ;
      endcase
    end
  end

  // Scan cursor and latched ack
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cur      <= base;
        cur_slot <= base_slot;
        cur_seq  <= base_seq;
        ack      <= item.ack_sequence;
      end
      OP_TICK, OP_ACK: begin
        cur      <= cur + 1'b1;
        cur_slot <= slot_inc(cur_slot);
        cur_seq  <= seq_inc(cur_seq);
      end
      default: ;
    endcase
  end

  // Ages and send counts
  always_ff @(posedge clk) begin
    if (op == OP_SEND) begin
      age[nxt_slot] <= '0;
      cnt[nxt_slot] <= CNT_W'(1);
    end else if (op == OP_TICK && tick_due) begin
      age[cur_slot] <= tick_hit ? '0 : age_inc;
      if (tick_hit) begin
        cnt[cur_slot] <= cnt_sat;
      end
    end
  end

  // Held beat marked as the closing one
  always_comb begin
    pend_last             = pend;
    pend_last.last_of_run = 1'b1;
  end

  // Result beats: one held back so the last one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (push) begin
        pend       <= res_new;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          result       <= pend;
          result_valid <= 1'b1;
        end
      end else if (op == OP_FLUSH) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          result       <= pend_last;
          result_valid <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/srarq_ctrl.sv
// Controller state machine: sequences start, tick and ack work over the window.
`default_nettype none
module srarq_ctrl import srarq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  item_t    item,
  input  dp_stat_t stat,
  output dp_op_t   op,
  output logic     busy
);

  state_t state, state_next;

  assign busy = (state != ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (item.command)
            CMD_START: begin
              op         = OP_START;
              state_next = stat.total_zero ? ST_DONE : ST_SEND;
            end
            CMD_TICK: begin
              if (stat.active) begin
                op         = OP_LOAD;
                state_next = ST_TICK;
              end
            end
            CMD_ACK: begin
              if (stat.active && item.ack_sequence != INFO_ACK) begin
                op         = OP_LOAD;
                state_next = ST_ACKSCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEND: begin
        if (stat.send_ok) begin
          op         = OP_SEND;
          state_next = stat.send_over ? ST_FAIL : ST_SEND;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_TICK: begin
        if (stat.scan_ok) begin
          op         = OP_TICK;
          state_next = stat.tick_over ? ST_FAIL : ST_TICK;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_ACKSCAN: begin
        if (stat.scan_ok) begin
          op         = OP_ACK;
          state_next = stat.ack_hit ? ST_SLIDE : ST_ACKSCAN;
        end else begin
          state_next = ST_SLIDE;
        end
      end
      ST_SLIDE: begin
        op = OP_SLIDE;
        if (!stat.slide_ok) begin
          state_next = stat.base_done ? ST_DONE : ST_SEND;
        end
      end
      ST_DONE: begin
        op         = OP_DONE;
        state_next = ST_FINISH;
      end
      ST_FAIL: begin
        op         = OP_FAIL;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        op         = OP_FLUSH;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
